@@ sv/vsf_pkg.sv @@
// shared types, constants and a helper function of the virtual spring follow controller
`default_nettype none
package vsf_pkg;

	localparam int CORDIC_STAGES_DEF = 16;

	localparam int VW   = 26;
	localparam int ZW   = 32;
	localparam int LW   = 17;
	localparam int NUMW = 62;
	localparam int QW   = NUMW - 23;
	localparam int FBW  = QW + 1;
	localparam int RW   = 34;
	localparam int CW   = 18;

	localparam logic [15:0] KINV   = 16'd39797;
	localparam logic [21:0] PI_Q20 = 22'd3294199;

	typedef enum logic [2:0] {
		REG_FOLLOW_ANGLE     = 3'd0,
		REG_FOLLOW_DISTANCE  = 3'd1,
		REG_SPRING_LINEAR    = 3'd2,
		REG_SPRING_ANGULAR   = 3'd3,
		REG_FRICTION_LINEAR  = 3'd4,
		REG_FRICTION_ANGULAR = 3'd5,
		REG_INVERSE_MASS     = 3'd6,
		REG_ROBOT_RADIUS     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] follow_angle;
		logic [14:0] follow_distance;
		logic [15:0] spring_linear;
		logic [23:0] spring_angular;
		logic [15:0] friction_linear;
		logic [15:0] friction_angular;
		logic [15:0] inverse_mass;
		logic [14:0] robot_radius;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		follow_angle:     16'd0,
		follow_distance:  15'd2867,
		spring_linear:    16'd768,
		spring_angular:   24'd1049,
		friction_linear:  16'd7680,
		friction_angular: 16'd5120,
		inverse_mass:     16'd2185,
		robot_radius:     15'd1229
	};

	typedef struct packed {
		logic [LW-1:0]      len;
		logic [ZW-1:0]      ang;
		logic signed [15:0] yaw;
		logic signed [15:0] vl;
		logic signed [15:0] va;
	} vec_t;

	typedef struct packed {
		logic [LW-1:0]        len;
		logic [ZW-1:0]        ang;
		logic signed [FBW-1:0] fb;
		logic signed [15:0]   vl;
		logic signed [15:0]   va;
	} div_t;

	typedef struct packed {
		logic [LW-1:0]         len;
		logic signed [FBW-1:0] fb;
		logic signed [CW-1:0]  cs;
		logic signed [CW-1:0]  sn;
		logic signed [15:0]    vl;
		logic signed [15:0]    va;
	} rot_t;

	typedef struct packed {
		logic signed [15:0] cl;
		logic signed [15:0] ca;
		logic               clip;
	} res_t;

	// arctan(2^-i) as a 32-bit binary angle
	function automatic logic [ZW-1:0] atan_ang(input int idx);
		logic [ZW-1:0] a;
		case (idx)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10680862;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

@@ sv/vsf_vec.sv @@
// vectoring cordic pipeline: spring length and angle of the negated person position
`default_nettype none
module vsf_vec #(
	parameter int STAGES = vsf_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [15:0] px,
	input  logic signed [15:0] py,
	input  logic signed [15:0] yaw,
	input  logic signed [15:0] vl,
	input  logic signed [15:0] va,
	output logic               out_valid,
	output vsf_pkg::vec_t      out_data
);
	import vsf_pkg::*;

	localparam int KPW = 42;
	localparam logic signed [KPW-1:0] LEN_RND = KPW'(2**21);

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic [ZW-1:0]        z;
		logic                 zero;
		logic signed [15:0]   yaw;
		logic signed [15:0]   vl;
		logic signed [15:0]   va;
	} cv_t;

	typedef struct packed {
		logic signed [KPW-1:0] kp;
		logic [ZW-1:0]         ang;
		logic signed [15:0]    yaw;
		logic signed [15:0]    vl;
		logic signed [15:0]    va;
	} km_t;

	logic signed [VW-1:0]  ax;
	logic signed [VW-1:0]  ay;
	logic signed [KPW-1:0] lr;
	cv_t                   cv_in;
	cv_t                   cv_s [STAGES+1];
	logic                  cv_vld_s [STAGES+1];
	km_t                   km_s1;
	logic                  vld_s1;
	vec_t                  ln_s2;
	logic                  vld_s2;

	// the vector is (-x, -y) scaled by 64; left half plane is turned by pi
	always_comb begin
		ax = {{(VW-22){px[15]}}, px, 6'b0};
		ay = {{(VW-22){py[15]}}, py, 6'b0};
		cv_in.zero = (px == '0) && (py == '0);
		cv_in.yaw  = yaw;
		cv_in.vl   = vl;
		cv_in.va   = va;
		if (!ax[VW-1] && ax != '0) begin
			cv_in.x = ax;
			cv_in.y = ay;
			cv_in.z = 32'h8000_0000;
		end else begin
			cv_in.x = -ax;
			cv_in.y = -ay;
			cv_in.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_vld_s[0] <= 1'b0;
		end else if (en) begin
			cv_vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cv_s[0] <= cv_in;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_cv
		cv_t nx;

		always_comb begin
			nx = cv_s[i];
			if (!cv_s[i].y[VW-1]) begin
				nx.x = cv_s[i].x + (cv_s[i].y >>> i);
				nx.y = cv_s[i].y - (cv_s[i].x >>> i);
				nx.z = cv_s[i].z + atan_ang(i);
			end else begin
				nx.x = cv_s[i].x - (cv_s[i].y >>> i);
				nx.y = cv_s[i].y + (cv_s[i].x >>> i);
				nx.z = cv_s[i].z - atan_ang(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				cv_vld_s[i+1] <= cv_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cv_s[i+1] <= nx;
			end
		end
	end

	// gain removal and rounding of the length
	always_comb begin
		lr = (km_s1.kp + LEN_RND) >>> 22;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cv_vld_s[STAGES];
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			km_s1.kp  <= KPW'(cv_s[STAGES].x) * $signed({1'b0, KINV});
			km_s1.ang <= cv_s[STAGES].zero ? '0 : cv_s[STAGES].z;
			km_s1.yaw <= cv_s[STAGES].yaw;
			km_s1.vl  <= cv_s[STAGES].vl;
			km_s1.va  <= cv_s[STAGES].va;
			ln_s2.len <= lr[LW-1:0];
			ln_s2.ang <= km_s1.ang;
			ln_s2.yaw <= km_s1.yaw;
			ln_s2.vl  <= km_s1.vl;
			ln_s2.va  <= km_s1.va;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = ln_s2;

endmodule
`default_nettype wire

@@ sv/vsf_div.sv @@
// bending force: spring angle, numerator products and a radix-2 restoring divider pipeline
`default_nettype none
module vsf_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  vsf_pkg::vec_t in_data,
	input  vsf_pkg::cfg_t cfg,
	output logic          out_valid,
	output vsf_pkg::div_t out_data
);
	import vsf_pkg::*;

	localparam int P1W = 40;
	localparam int PHW = P1W / 2;
	localparam int HPW = PHW + 22;

	typedef struct packed {
		logic [LW-1:0]      len;
		logic [ZW-1:0]      ang;
		logic signed [15:0] vl;
		logic signed [15:0] va;
		logic               neg;
	} ctx_t;

	typedef struct packed {
		ctx_t          c;
		logic [LW-1:0] rem;
		logic [QW-1:0] dvd;
		logic [QW-1:0] q;
	} dv_t;

	logic [15:0]           theta;
	logic [15:0]           a16;
	logic [15:0]           phi;
	logic [NUMW-1:0]       num;
	dv_t                   dv_in;
	logic signed [FBW-1:0] fbm;

	ctx_t                  c_s1;
	logic [15:0]           mag_s1;
	logic                  vld_s1;
	ctx_t                  c_s2;
	logic [P1W-1:0]        p1_s2;
	logic                  vld_s2;
	ctx_t                  c_s3;
	logic [HPW-1:0]        hi_s3;
	logic [HPW-1:0]        lo_s3;
	logic                  vld_s3;
	dv_t                   dv_s [QW+1];
	logic                  dv_vld_s [QW+1];
	div_t                  od_s5;
	logic                  od_vld_s5;

	// spring angle phi, wrapped 16-bit binary angle
	always_comb begin
		theta = in_data.yaw + cfg.follow_angle;
		a16   = 16'((in_data.ang + 32'h0000_8000) >> 16);
		phi   = a16 - theta;
	end

	always_comb begin
		num       = {hi_s3, {PHW{1'b0}}} + NUMW'(lo_s3);
		dv_in.c   = c_s3;
		dv_in.rem = '0;
		dv_in.dvd = num[NUMW-1 -: QW];
		dv_in.q   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			dv_vld_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1.len <= in_data.len;
			c_s1.ang <= in_data.ang;
			c_s1.vl  <= in_data.vl;
			c_s1.va  <= in_data.va;
			c_s1.neg <= phi[15];
			mag_s1   <= phi[15] ? 16'(-phi) : phi;
			c_s2     <= c_s1;
			p1_s2    <= cfg.spring_angular * mag_s1;
			c_s3     <= c_s2;
			hi_s3    <= p1_s2[P1W-1:PHW] * PI_Q20;
			lo_s3    <= p1_s2[PHW-1:0] * PI_Q20;
			dv_s[0]  <= dv_in;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_dv
		logic [LW:0] t;
		logic        ge;
		dv_t         nx;

		always_comb begin
			t      = {dv_s[i].rem, dv_s[i].dvd[QW-1]};
			ge     = t >= {1'b0, dv_s[i].c.len};
			nx     = dv_s[i];
			nx.rem = ge ? LW'(t - {1'b0, dv_s[i].c.len}) : t[LW-1:0];
			nx.dvd = dv_s[i].dvd << 1;
			nx.q   = {dv_s[i].q[QW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[i+1] <= dv_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[i+1] <= nx;
			end
		end
	end

	// zero length gives no bending force
	always_comb begin
		fbm = $signed({1'b0, dv_s[QW].q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			od_vld_s5 <= 1'b0;
		end else if (en) begin
			od_vld_s5 <= dv_vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			od_s5.len <= dv_s[QW].c.len;
			od_s5.ang <= dv_s[QW].c.ang;
			od_s5.vl  <= dv_s[QW].c.vl;
			od_s5.va  <= dv_s[QW].c.va;
			if (dv_s[QW].c.len == '0) begin
				od_s5.fb <= '0;
			end else begin
				od_s5.fb <= dv_s[QW].c.neg ? -fbm : fbm;
			end
		end
	end

	assign out_valid = od_vld_s5;
	assign out_data  = od_s5;

endmodule
`default_nettype wire

@@ sv/vsf_rot.sv @@
// rotation cordic pipeline: cosine and sine of the negated spring angle
`default_nettype none
module vsf_rot #(
	parameter int STAGES = vsf_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  vsf_pkg::div_t in_data,
	output logic          out_valid,
	output vsf_pkg::rot_t out_data
);
	import vsf_pkg::*;

	localparam logic signed [RW-1:0] HALF_PI = RW'(1) <<< 30;
	localparam logic signed [RW-1:0] PI_A    = RW'(1) <<< 31;
	localparam logic signed [RW-1:0] X0      = RW'({KINV, 14'b0});
	localparam logic signed [RW-1:0] RND14   = RW'(1) <<< 13;

	typedef struct packed {
		logic signed [RW-1:0]  x;
		logic signed [RW-1:0]  y;
		logic signed [RW-1:0]  d;
		logic                  flip;
		logic [LW-1:0]         len;
		logic signed [FBW-1:0] fb;
		logic signed [15:0]    vl;
		logic signed [15:0]    va;
	} rt_t;

	logic [ZW-1:0]        dn;
	logic signed [RW-1:0] dx;
	logic signed [RW-1:0] cr;
	logic signed [RW-1:0] sr;
	rt_t                  rt_in;
	rt_t                  rt_s [STAGES+1];
	logic                 rt_vld_s [STAGES+1];
	rot_t                 or_s2;
	logic                 or_vld_s2;

	// fold the angle into the right half plane
	always_comb begin
		dn          = '0 - in_data.ang;
		dx          = RW'($signed(dn));
		rt_in.x     = X0;
		rt_in.y     = '0;
		rt_in.len   = in_data.len;
		rt_in.fb    = in_data.fb;
		rt_in.vl    = in_data.vl;
		rt_in.va    = in_data.va;
		rt_in.d     = dx;
		rt_in.flip  = 1'b0;
		if (dx > HALF_PI) begin
			rt_in.d    = dx - PI_A;
			rt_in.flip = 1'b1;
		end else if (dx < -HALF_PI) begin
			rt_in.d    = dx + PI_A;
			rt_in.flip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_vld_s[0] <= 1'b0;
		end else if (en) begin
			rt_vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0] <= rt_in;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rt
		rt_t nx;

		always_comb begin
			nx = rt_s[i];
			if (!rt_s[i].d[RW-1]) begin
				nx.x = rt_s[i].x - (rt_s[i].y >>> i);
				nx.y = rt_s[i].y + (rt_s[i].x >>> i);
				nx.d = rt_s[i].d - RW'(atan_ang(i));
			end else begin
				nx.x = rt_s[i].x + (rt_s[i].y >>> i);
				nx.y = rt_s[i].y - (rt_s[i].x >>> i);
				nx.d = rt_s[i].d + RW'(atan_ang(i));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[i+1] <= rt_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[i+1] <= nx;
			end
		end
	end

	always_comb begin
		cr = (rt_s[STAGES].x + RND14) >>> 14;
		sr = (rt_s[STAGES].y + RND14) >>> 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			or_vld_s2 <= 1'b0;
		end else if (en) begin
			or_vld_s2 <= rt_vld_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			or_s2.len <= rt_s[STAGES].len;
			or_s2.fb  <= rt_s[STAGES].fb;
			or_s2.vl  <= rt_s[STAGES].vl;
			or_s2.va  <= rt_s[STAGES].va;
			or_s2.cs  <= rt_s[STAGES].flip ? -cr[CW-1:0] : cr[CW-1:0];
			or_s2.sn  <= rt_s[STAGES].flip ? -sr[CW-1:0] : sr[CW-1:0];
		end
	end

	assign out_valid = or_vld_s2;
	assign out_data  = or_s2;

endmodule
`default_nettype wire

@@ sv/vsf_force.sv @@
// force sums, friction, mass and radius scaling, rounding and saturation of the commands
`default_nettype none
module vsf_force (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  vsf_pkg::rot_t in_data,
	input  vsf_pkg::cfg_t cfg,
	output logic          out_valid,
	output vsf_pkg::res_t out_data
);
	import vsf_pkg::*;

	localparam int FEW  = 35;
	localparam int FRW  = 33;
	localparam int PW   = FBW + CW;
	localparam int SW   = PW + 2;
	localparam int S20W = SW - 16;
	localparam int MW   = S20W + 17;

	localparam logic signed [SW-1:0] RND16 = SW'(1) <<< 15;
	localparam logic signed [MW-1:0] RND24 = MW'(1) <<< 23;
	localparam logic signed [MW-1:0] RND20 = MW'(1) <<< 19;
	localparam logic signed [MW-1:0] MAXV  = MW'(32767);
	localparam logic signed [MW-1:0] MINV  = MW'(-32768);

	typedef struct packed {
		logic signed [FEW-1:0] fe;
		logic signed [FRW-1:0] frl;
		logic signed [FRW-1:0] fra;
		logic signed [FBW-1:0] fb;
		logic signed [CW-1:0]  cs;
		logic signed [CW-1:0]  sn;
	} f1_t;

	typedef struct packed {
		logic signed [PW-1:0]  fc;
		logic signed [PW-1:0]  fs;
		logic signed [PW-1:0]  bs;
		logic signed [PW-1:0]  bc;
		logic signed [FRW-1:0] frl;
		logic signed [FRW-1:0] fra;
	} f2_t;

	logic signed [LW:0]    lmd;
	logic signed [SW-1:0]  rl4;
	logic signed [SW-1:0]  ra4;
	logic signed [MW-1:0]  rl6;
	logic signed [MW-1:0]  ra6;

	f1_t                   f1_s1;
	f2_t                   f2_s2;
	logic signed [SW-1:0]  sl_s3;
	logic signed [SW-1:0]  sa_s3;
	logic signed [S20W-1:0] tl_s4;
	logic signed [S20W-1:0] ta_s4;
	logic signed [MW-1:0]  pl_s5;
	logic signed [MW-1:0]  pa_s5;
	res_t                  rs_s6;
	logic [5:0]            vld_s;

	function automatic logic signed [15:0] sat16(input logic signed [MW-1:0] v);
		logic signed [15:0] r;
		if (v > MAXV) begin
			r = 16'sh7fff;
		end else if (v < MINV) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	always_comb begin
		lmd = $signed({1'b0, in_data.len}) - $signed({3'b0, cfg.follow_distance});
		rl4 = (sl_s3 + RND16) >>> 16;
		ra4 = (sa_s3 + RND16) >>> 16;
		rl6 = (pl_s5 + RND24) >>> 24;
		ra6 = (pa_s5 + RND20) >>> 20;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s1.fe  <= $signed({1'b0, cfg.spring_linear}) * lmd;
			f1_s1.frl <= $signed({1'b0, cfg.friction_linear}) * in_data.vl;
			f1_s1.fra <= $signed({1'b0, cfg.friction_angular}) * in_data.va;
			f1_s1.fb  <= in_data.fb;
			f1_s1.cs  <= in_data.cs;
			f1_s1.sn  <= in_data.sn;

			f2_s2.fc  <= f1_s1.fe * f1_s1.cs;
			f2_s2.fs  <= f1_s1.fe * f1_s1.sn;
			f2_s2.bs  <= f1_s1.fb * f1_s1.sn;
			f2_s2.bc  <= f1_s1.fb * f1_s1.cs;
			f2_s2.frl <= f1_s1.frl;
			f2_s2.fra <= f1_s1.fra;

			sl_s3 <= -SW'(f2_s2.fc) - SW'(f2_s2.bs) - (SW'(f2_s2.frl) <<< 16);
			sa_s3 <= -SW'(f2_s2.fs) - SW'(f2_s2.bc) - (SW'(f2_s2.fra) <<< 16);

			tl_s4 <= rl4[S20W-1:0];
			ta_s4 <= ra4[S20W-1:0];

			pl_s5 <= MW'(tl_s4) * $signed({1'b0, cfg.inverse_mass});
			pa_s5 <= MW'(ta_s4) * $signed({2'b0, cfg.robot_radius});

			rs_s6.cl   <= sat16(rl6);
			rs_s6.ca   <= sat16(ra6);
			rs_s6.clip <= (rl6 > MAXV) || (rl6 < MINV) || (ra6 > MAXV) || (ra6 < MINV);
		end
	end

	assign out_valid = vld_s[5];
	assign out_data  = rs_s6;

endmodule
`default_nettype wire

@@ sv/virtual_spring_follow_control.sv @@
// top level of the virtual spring person follow controller
`default_nettype none
// Takes one person pose with the robot's speed per beat and returns one linear and one
// angular velocity command, saturated to 16 bits, with a flag that marks saturation. The
// datapath is a single pipeline with no state between poses, so a new beat is accepted on
// every clock while the output side keeps up. Each pose passes through the two cordic
// pipelines of CORDIC_STAGES steps each and through the 39-step restoring divider of the
// bending force. A two-entry output stage keeps accepting while a result waits, and
// in_ready falls only when both entries are full. Registers are written through
// cfg_we/cfg_index/cfg_data and should only change while the pipeline is empty.
module virtual_spring_follow_control #(
	parameter int CORDIC_STAGES = vsf_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] person_x,
	input  logic signed [15:0] person_y,
	input  logic signed [15:0] person_yaw,
	input  logic signed [15:0] speed_linear,
	input  logic signed [15:0] speed_angular,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] command_linear,
	output logic signed [15:0] command_angular,
	output logic               clipped,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import vsf_pkg::*;

	cfg_t cfg_q;
	logic en;
	logic vec_vld;
	vec_t vec_d;
	logic div_vld;
	div_t div_d;
	logic rot_vld;
	rot_t rot_d;
	logic res_vld;
	res_t res_d;
	res_t out_q;
	logic out_vld_q;
	res_t sk_q;
	logic sk_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FOLLOW_ANGLE:     cfg_q.follow_angle     <= cfg_data[15:0];
				REG_FOLLOW_DISTANCE:  cfg_q.follow_distance  <= cfg_data[14:0];
				REG_SPRING_LINEAR:    cfg_q.spring_linear    <= cfg_data[15:0];
				REG_SPRING_ANGULAR:   cfg_q.spring_angular   <= cfg_data[23:0];
				REG_FRICTION_LINEAR:  cfg_q.friction_linear  <= cfg_data[15:0];
				REG_FRICTION_ANGULAR: cfg_q.friction_angular <= cfg_data[15:0];
				REG_INVERSE_MASS:     cfg_q.inverse_mass     <= cfg_data[15:0];
				REG_ROBOT_RADIUS:     cfg_q.robot_radius     <= cfg_data[14:0];
			endcase
		end
	end

	assign en       = !sk_vld_q;
	assign in_ready = en;

	vsf_vec #(
		.STAGES(CORDIC_STAGES)
	) u_vec (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.px       (person_x),
		.py       (person_y),
		.yaw      (person_yaw),
		.vl       (speed_linear),
		.va       (speed_angular),
		.out_valid(vec_vld),
		.out_data (vec_d)
	);

	vsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vec_vld),
		.in_data  (vec_d),
		.cfg      (cfg_q),
		.out_valid(div_vld),
		.out_data (div_d)
	);

	vsf_rot #(
		.STAGES(CORDIC_STAGES)
	) u_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_vld),
		.in_data  (div_d),
		.out_valid(rot_vld),
		.out_data (rot_d)
	);

	vsf_force u_force (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (rot_vld),
		.in_data  (rot_d),
		.cfg      (cfg_q),
		.out_valid(res_vld),
		.out_data (res_d)
	);

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q  <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (sk_vld_q) begin
				out_vld_q <= 1'b1;
				sk_vld_q  <= 1'b0;
			end else begin
				out_vld_q <= res_vld;
			end
		end else if (res_vld && !sk_vld_q) begin
			sk_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			out_q <= sk_vld_q ? sk_q : res_d;
		end else if (!sk_vld_q) begin
			sk_q <= res_d;
		end
	end

	assign out_valid       = out_vld_q;
	assign command_linear  = out_q.cl;
	assign command_angular = out_q.ca;
	assign clipped         = out_q.clip;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_vld_q |-> out_vld_q)
		else $error("skid entry holds a beat while output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(sk_vld_q && !out_ready) |=> sk_vld_q)
		else $error("skid beat dropped while output stalled");

	a_clip_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && command_linear != 16'h7fff && command_linear != 16'h8000
			&& command_angular != 16'h7fff && command_angular != 16'h8000) |-> !clipped)
		else $error("clip flag set without a command at its limit");

endmodule
`default_nettype wire
